// ----- hdl/kmsmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsmt_pkg
// Shared types and constants of the key matrix scanner with mode toggle.
// ----------------------------------------------------------------------------
package kmsmt_pkg;

  localparam int RowW   = 3;
  localparam int ColW   = 8;
  localparam int KeyW   = 7;
  localparam int CfgW   = 6;
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  // key index meaning "no key"
  localparam logic [KeyW-1:0] KEY_NONE = 7'h7F;

  // configuration register indexes
  localparam logic CFG_OCT_UP = 1'b0;
  localparam logic CFG_OCT_DN = 1'b1;

  localparam logic [CfgW-1:0] OCT_UP_RST = 6'd0;
  localparam logic [CfgW-1:0] OCT_DN_RST = 6'd1;

  // classified row word handed from the front end to the back end
  typedef struct packed {
    logic            row_ok;  // row is inside the matrix
    logic [RowW-1:0] row;
    logic [ColW-1:0] press;   // 1 = key down, unused columns cleared
    logic            last;    // end of scan
  } item_t;

  // front end queue output toward the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// ----- hdl/kmsmt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsmt_front
// Accepts row samples, classifies them and holds them in a two-word queue.
// ----------------------------------------------------------------------------
module kmsmt_front #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kmsmt_pkg::RowW-1:0]  in_row_i,
  input  logic [kmsmt_pkg::ColW-1:0]  in_levels_i,
  input  logic                        in_last_i,
  output kmsmt_pkg::queue_out_t       q_o,
  input  logic                        q_pop_i
);

  localparam logic [kmsmt_pkg::ColW-1:0] ColMask = kmsmt_pkg::ColW'((1 << COLS) - 1);

  kmsmt_pkg::item_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push;
  kmsmt_pkg::item_t item_in;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    item_in.row_ok = ({1'b0, in_row_i} < 4'(ROWS));
    item_in.row    = in_row_i;
    item_in.press  = ~in_levels_i & ColMask;
    item_in.last   = in_last_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign q_o.valid = (count_q != 2'd0);
  assign q_o.item  = mem_q[rd_ptr_q];

endmodule

// ----- hdl/kmsmt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsmt_back
// Key state update, press/release tracking, chord mode toggle, output register.
// ----------------------------------------------------------------------------
module kmsmt_back #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [kmsmt_pkg::CfgW-1:0]    cfg_wdata_i,
  input  kmsmt_pkg::queue_out_t         q_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kmsmt_pkg::KeyW-1:0]    out_pressed_o,
  output logic [kmsmt_pkg::KeyW-1:0]    out_released_o,
  output logic                          out_event_o,
  output logic                          out_mode_o,
  output logic                          out_toggled_o
);

  localparam int NKeys = ROWS * COLS;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

  kmsmt_pkg::item_t it;

  logic [NKeys-1:0]             key_down_q, key_down_d;
  logic [kmsmt_pkg::KeyW-1:0]   press_q, press_d;
  logic [kmsmt_pkg::KeyW-1:0]   release_q, release_d;
  logic                         chord_wait_q, chord_wait_d;
  logic                         mode_q, mode_d;
  logic [kmsmt_pkg::CfgW-1:0]   oct_up_q, oct_dn_q;

  logic                         out_valid_q;
  logic                         out_event_q, out_event_d;
  logic                         out_toggled_q, out_toggled_d;

  logic                         load;
  logic [COLS-1:0]              press_row, old_row, changed;
  logic                         hit;
  logic [CW-1:0]                hit_col;
  logic [kmsmt_pkg::KeyW-1:0]   key_idx;
  logic                         up_down, dn_down, fire;

  assign it      = q_i.item;
  assign load    = q_i.valid && (!out_valid_q || out_ready_i);
  assign q_pop_o = load;

  // new state of every key; only the addressed row follows the sample
  for (genvar k = 0; k < NKeys; k++) begin : g_key
    localparam int KR = k / COLS;
    localparam int KC = k % COLS;
    assign key_down_d[k] = (it.row_ok && it.row == kmsmt_pkg::RowW'(KR)) ?
                           it.press[KC] : key_down_q[k];
  end

  assign press_row = it.press[COLS-1:0];

  always_comb begin
    old_row = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (it.row == kmsmt_pkg::RowW'(r)) begin
        for (int c = 0; c < COLS; c++) begin
          old_row[c] = key_down_q[r*COLS + c];
        end
      end
    end
    changed = it.row_ok ? (old_row ^ press_row) : '0;
  end

  // highest changed column decides
  always_comb begin
    hit     = 1'b0;
    hit_col = '0;
    for (int c = 0; c < COLS; c++) begin
      if (changed[c]) begin
        hit     = 1'b1;
        hit_col = CW'(c);
      end
    end
    key_idx = kmsmt_pkg::KeyW'(it.row) * kmsmt_pkg::KeyW'(COLS) + kmsmt_pkg::KeyW'(hit_col);
  end

  // chord keys read from the updated key state; out-of-range index never matches
  always_comb begin
    up_down = 1'b0;
    dn_down = 1'b0;
    for (int k = 0; k < NKeys; k++) begin
      up_down = up_down | (key_down_d[k] && oct_up_q == kmsmt_pkg::CfgW'(k));
      dn_down = dn_down | (key_down_d[k] && oct_dn_q == kmsmt_pkg::CfgW'(k));
    end
  end

  always_comb begin
    press_d       = press_q;
    release_d     = release_q;
    chord_wait_d  = chord_wait_q;
    mode_d        = mode_q;
    fire          = 1'b0;
    if (hit) begin
      if (press_row[hit_col]) begin
        press_d   = key_idx;
        release_d = kmsmt_pkg::KEY_NONE;
      end else begin
        release_d = key_idx;
        press_d   = kmsmt_pkg::KEY_NONE;
      end
    end
    if (it.last) begin
      if (!chord_wait_q) begin
        chord_wait_d = up_down && dn_down;
      end else if (!up_down && !dn_down) begin
        fire         = 1'b1;
        mode_d       = ~mode_q;
        chord_wait_d = 1'b0;
        release_d    = kmsmt_pkg::KEY_NONE;
      end
    end
    out_event_d   = hit;
    out_toggled_d = fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_up_q <= kmsmt_pkg::OCT_UP_RST;
      oct_dn_q <= kmsmt_pkg::OCT_DN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kmsmt_pkg::CFG_OCT_UP: oct_up_q <= cfg_wdata_i;
        kmsmt_pkg::CFG_OCT_DN: oct_dn_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_down_q    <= '0;
      press_q       <= kmsmt_pkg::KEY_NONE;
      release_q     <= kmsmt_pkg::KEY_NONE;
      chord_wait_q  <= 1'b0;
      mode_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      out_event_q   <= 1'b0;
      out_toggled_q <= 1'b0;
    end else begin
      if (load) begin
        key_down_q    <= key_down_d;
        press_q       <= press_d;
        release_q     <= release_d;
        chord_wait_q  <= chord_wait_d;
        mode_q        <= mode_d;
        out_event_q   <= out_event_d;
        out_toggled_q <= out_toggled_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // output word is the tracked state after the item
  assign out_valid_o    = out_valid_q;
  assign out_pressed_o  = press_q;
  assign out_released_o = release_q;
  assign out_event_o    = out_event_q;
  assign out_mode_o     = mode_q;
  assign out_toggled_o  = out_toggled_q;

`ifndef SYNTHESIS
  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (press_q == kmsmt_pkg::KEY_NONE) || (release_q == kmsmt_pkg::KEY_NONE))
    else $error("pressed and released keys both set");

  a_toggle_clears_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_toggled_q) |-> (release_q == kmsmt_pkg::KEY_NONE))
    else $error("mode toggle left a released key");

  a_toggle_needs_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && fire) |=> (!chord_wait_q && $past(chord_wait_q) && mode_q != $past(mode_q)))
    else $error("mode toggle without armed chord");

  a_no_event_off_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !it.row_ok) |=> (!out_event_q && $stable(key_down_q)))
    else $error("key state changed on row outside matrix");
`endif

endmodule

// ----- hdl/key_matrix_scan_with_mode_toggle_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scan_with_mode_toggle_top
// Key matrix row scanner with press/release reporting and chord mode toggle.
// ----------------------------------------------------------------------------
// Path: an accepted word goes into the input queue, then into the output register,
//   from which it is offered on m_axis; key update and chord check are one stage.
// Throughput: one row word per cycle while m_axis does not stall.
// A two-word queue lets input accept while a result waits on m_axis.
// Reset (rst_ni low, async): all keys released, no key reported, current_mode 0,
//   chord idle, chord keys 0 and 1, queue and output empty.
module key_matrix_scan_with_mode_toggle_top #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [kmsmt_pkg::InDataW-1:0]     s_axis_tdata,   // row[2:0], col_levels[10:3]
  input  logic                              s_axis_tlast,   // last_row
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [kmsmt_pkg::OutDataW-1:0]    m_axis_tdata,   // pressed_key[6:0],
                                                            // released_key[13:7],
                                                            // key_event[14],
                                                            // current_mode[15],
                                                            // mode_toggled[16]
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [kmsmt_pkg::CfgW-1:0]        cfg_wdata_i
);

  kmsmt_pkg::queue_out_t       q;
  logic                        q_pop;
  logic [kmsmt_pkg::KeyW-1:0]  pressed_key, released_key;
  logic                        key_event, current_mode, mode_toggled;

  kmsmt_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_row_i    (s_axis_tdata[2:0]),
    .in_levels_i (s_axis_tdata[10:3]),
    .in_last_i   (s_axis_tlast),
    .q_o         (q),
    .q_pop_i     (q_pop)
  );

  kmsmt_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_i            (q),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_pressed_o  (pressed_key),
    .out_released_o (released_key),
    .out_event_o    (key_event),
    .out_mode_o     (current_mode),
    .out_toggled_o  (mode_toggled)
  );

  assign m_axis_tdata = {7'd0, mode_toggled, current_mode, key_event,
                         released_key, pressed_key};

endmodule
